// ===== rtl/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg
// shared constants, codes and control bundles of the rebinning block
// accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package rba_pkg;

	// sizing of the per-variable block table
	localparam int NUM_VARS   = 16;
	localparam int MAX_BLOCKS = 64;
	localparam int VAR_W      = $clog2(NUM_VARS);
	localparam int BLK_W      = $clog2(MAX_BLOCKS);
	localparam int PAIR_W     = BLK_W - 1;
	localparam int ADDR_W     = VAR_W + BLK_W;
	localparam int DEPTH      = NUM_VARS * MAX_BLOCKS;

	// field widths
	localparam int OP_W     = 2;
	localparam int STS_W    = 2;
	localparam int VAL_W    = 24;
	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_W    = 32;
	localparam int FILL_W   = 31;
	localparam int MEAS_W   = 32;
	localparam int SUM_W    = 56;
	localparam int SQ_W     = 63;
	localparam int EXP_W    = 5;
	localparam int PROD_W   = 2 * VAL_W - 1;
	localparam int MEASX_W  = CNT_W + LEN_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int VCFG_W     = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_VARS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = CFG_IDX_W'(1);

	localparam logic [VCFG_W-1:0] VARS_MIN  = VCFG_W'(1);
	localparam logic [VCFG_W-1:0] VARS_MAX  = VCFG_W'(NUM_VARS);
	localparam logic [CNT_W-1:0]  BLKS_MIN  = CNT_W'(2);
	localparam logic [CNT_W-1:0]  BLKS_MAX  = CNT_W'(MAX_BLOCKS);
	localparam logic [EXP_W-1:0]  EXP_MAX   = {EXP_W{1'b1}};

	// saturation bounds
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};
	localparam logic [MEASX_W-1:0]      MEAS_FULL =
		{{(MEASX_W-MEAS_W){1'b0}}, {MEAS_W{1'b1}}};

	typedef enum logic [OP_W-1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 2'd0,
		STS_BAD_VAR = 2'd1,
		STS_BAD_BLK = 2'd2,
		STS_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MRG_A,
		S_MRG_B,
		S_MRG_W,
		S_ACC_RD
	} seq_state_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic accept;
		logic need_merge;
		logic out_free;
		logic merge_last;
	} seq_stat_t;

	// sequencer strobes toward the datapath
	typedef struct packed {
		logic idle;
		logic exec;
		logic mrg_a;
		logic mrg_b;
		logic mrg_w;
		logic acc_rd;
		logic commit;
	} seq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rba_sum_ram.sv =====
// ----------------------------------------------------------------------------
// rba_sum_ram
// block sum store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rba_sum_ram (
	input  wire logic                              clk,
	input  wire logic                              wr_en,
	input  wire logic [rba_pkg::ADDR_W-1:0]        wr_addr,
	input  wire logic signed [rba_pkg::SUM_W-1:0]  wr_data,
	input  wire logic                              rd_en,
	input  wire logic [rba_pkg::ADDR_W-1:0]        rd_addr,
	output logic signed [rba_pkg::SUM_W-1:0]       rd_data
);

	logic [rba_pkg::SUM_W-1:0] mem [rba_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rba_sat_add.sv =====
// ----------------------------------------------------------------------------
// rba_sat_add
// shared saturating block sum adder for accumulates and pair merges
// ----------------------------------------------------------------------------
`default_nettype none

module rba_sat_add (
	input  wire logic signed [rba_pkg::SUM_W-1:0] a,
	input  wire logic signed [rba_pkg::SUM_W-1:0] b,
	output logic signed [rba_pkg::SUM_W-1:0]      sum
);

	logic signed [rba_pkg::SUM_W:0] sum_x;

	assign sum_x = {a[rba_pkg::SUM_W-1], a} + {b[rba_pkg::SUM_W-1], b};

	always_comb begin
		if (sum_x[rba_pkg::SUM_W] != sum_x[rba_pkg::SUM_W-1]) begin
			sum = sum_x[rba_pkg::SUM_W] ? rba_pkg::SUM_MIN : rba_pkg::SUM_MAX;
		end else begin
			sum = sum_x[rba_pkg::SUM_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rba_seq.sv =====
// ----------------------------------------------------------------------------
// rba_seq
// sequencer: item execution, pairwise merge sweep and re-read
// ----------------------------------------------------------------------------
`default_nettype none

module rba_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rba_pkg::seq_stat_t  stat,
	output rba_pkg::seq_ctrl_t       ctrl
);

	rba_pkg::seq_state_t state_q;
	rba_pkg::seq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rba_pkg::S_IDLE: begin
				if (stat.accept) begin
					state_d = rba_pkg::S_EXEC;
				end
			end
			rba_pkg::S_EXEC: begin
				if (stat.need_merge) begin
					state_d = rba_pkg::S_MRG_A;
				end else if (stat.out_free) begin
					state_d = rba_pkg::S_IDLE;
				end
			end
			rba_pkg::S_MRG_A: state_d = rba_pkg::S_MRG_B;
			rba_pkg::S_MRG_B: state_d = rba_pkg::S_MRG_W;
			rba_pkg::S_MRG_W: begin
				state_d = stat.merge_last ? rba_pkg::S_ACC_RD : rba_pkg::S_MRG_B;
			end
			rba_pkg::S_ACC_RD: state_d = rba_pkg::S_EXEC;
			default: state_d = rba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl        = '0;
		ctrl.idle   = (state_q == rba_pkg::S_IDLE);
		ctrl.exec   = (state_q == rba_pkg::S_EXEC);
		ctrl.mrg_a  = (state_q == rba_pkg::S_MRG_A);
		ctrl.mrg_b  = (state_q == rba_pkg::S_MRG_B);
		ctrl.mrg_w  = (state_q == rba_pkg::S_MRG_W);
		ctrl.acc_rd = (state_q == rba_pkg::S_ACC_RD);
		ctrl.commit = ctrl.exec && !stat.need_merge && stat.out_free;
	end

endmodule

`default_nettype wire

// ===== rtl/rebinning_block_accumulator_top.sv =====
// a beat accepted from idle lands in the item registers; its result beat is registered when
// the item commits its read-modify-write of the block sum ram, and no new item is taken before
// that commit; an accumulate that finds the table full first sweeps the pair merges through
// the one ram read port and the shared adder (mrg_a, then mrg_b and mrg_w per pair, then acc_rd)
// reset: async, clears control, config (16 vars, 64 blocks) and per-variable counters;
// the block sum ram is not swept, entries past the fill of a variable read as zero
// ----------------------------------------------------------------------------
// rebinning_block_accumulator_top
// per-variable data-blocking accumulator with pairwise rebinning of full tables
// ----------------------------------------------------------------------------
`default_nettype none

module rebinning_block_accumulator_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// item channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [rba_pkg::OP_W-1:0]              op,
	input  wire logic [rba_pkg::VAR_W-1:0]             var_index,
	input  wire logic signed [rba_pkg::VAL_W-1:0]      value,
	input  wire logic [rba_pkg::BLK_W-1:0]             block_index,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [rba_pkg::STS_W-1:0]                  status,
	output logic [rba_pkg::CNT_W-1:0]                  block_count,
	output logic [rba_pkg::LEN_W-1:0]                  block_length,
	output logic [rba_pkg::FILL_W-1:0]                 partial_fill,
	output logic [rba_pkg::MEAS_W-1:0]                 measurements,
	output logic signed [rba_pkg::SUM_W-1:0]           block_sum,
	output logic [rba_pkg::SQ_W-1:0]                   square_sum,
	// configuration writes
	input  wire logic                                  cfg_we,
	input  wire logic [rba_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rba_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	rba_pkg::seq_stat_t stat;
	rba_pkg::seq_ctrl_t ctrl;

	rba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	logic in_fire;
	logic out_free;

	// items are taken only while the sequencer sits idle; a waiting result
	// beat sits in the output register and does not block taking the next item, only its commit
	assign in_stall = !ctrl.idle;
	assign in_fire  = in_valid && ctrl.idle;
	assign out_free = !out_valid || !out_stall;

	// ------------------------------------------------------------------
	// configuration, kept as effective (clamped) values
	// ------------------------------------------------------------------
	logic [rba_pkg::VCFG_W-1:0] vars_eff_q;
	logic [rba_pkg::CNT_W-1:0]  nb_q;
	logic [rba_pkg::VCFG_W-1:0] cfg_vars;
	logic [rba_pkg::CNT_W-1:0]  cfg_blks;
	logic                       cfg_hit;

	assign cfg_hit = cfg_we
		&& (cfg_index == rba_pkg::CFG_VARS || cfg_index == rba_pkg::CFG_BLOCKS);

	always_comb begin
		cfg_vars = cfg_data[rba_pkg::VCFG_W-1:0];
		if (cfg_vars < rba_pkg::VARS_MIN) begin
			cfg_vars = rba_pkg::VARS_MIN;
		end else if (cfg_vars > rba_pkg::VARS_MAX) begin
			cfg_vars = rba_pkg::VARS_MAX;
		end
		// lowest bit ignored, then clamped into the table
		cfg_blks = {cfg_data[rba_pkg::CNT_W-1:1], 1'b0};
		if (cfg_blks > rba_pkg::BLKS_MAX) begin
			cfg_blks = rba_pkg::BLKS_MAX;
		end else if (cfg_blks < rba_pkg::BLKS_MIN) begin
			cfg_blks = rba_pkg::BLKS_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_eff_q <= rba_pkg::VARS_MAX;
			nb_q       <= rba_pkg::BLKS_MAX;
		end else if (cfg_we) begin
			if (cfg_index == rba_pkg::CFG_VARS) begin
				vars_eff_q <= cfg_vars;
			end
			if (cfg_index == rba_pkg::CFG_BLOCKS) begin
				nb_q <= cfg_blks;
			end
		end
	end

	// ------------------------------------------------------------------
	// item registers, captured on the accepted beat
	// ------------------------------------------------------------------
	rba_pkg::op_t                      op_q;
	logic [rba_pkg::VAR_W-1:0]         var_q;
	logic signed [rba_pkg::VAL_W-1:0]  val_q;
	logic [rba_pkg::BLK_W-1:0]         blk_q;
	logic [rba_pkg::PROD_W-1:0]        prod_q;
	logic signed [2*rba_pkg::VAL_W-1:0] sq_full;

	// square of the sample, registered before it meets the square sum
	assign sq_full = value * value;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= rba_pkg::op_t'(op);
			var_q  <= var_index;
			val_q  <= value;
			blk_q  <= block_index;
			prod_q <= sq_full[rba_pkg::PROD_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// per-variable counters and square sums
	// ------------------------------------------------------------------
	logic [rba_pkg::CNT_W-1:0]  comp_q [rba_pkg::NUM_VARS];
	logic [rba_pkg::EXP_W-1:0]  exp_q  [rba_pkg::NUM_VARS];
	logic [rba_pkg::FILL_W-1:0] fill_q [rba_pkg::NUM_VARS];
	logic [rba_pkg::SQ_W-1:0]   sq_q   [rba_pkg::NUM_VARS];

	logic [rba_pkg::CNT_W-1:0]   cur_comp;
	logic [rba_pkg::EXP_W-1:0]   cur_exp;
	logic [rba_pkg::FILL_W-1:0]  cur_fill;
	logic [rba_pkg::SQ_W-1:0]    cur_sq;
	logic [rba_pkg::LEN_W-1:0]   cur_len;
	logic [rba_pkg::MEASX_W-1:0] meas_cur;

	assign cur_comp = comp_q[var_q];
	assign cur_exp  = exp_q[var_q];
	assign cur_fill = fill_q[var_q];
	assign cur_sq   = sq_q[var_q];
	assign cur_len  = rba_pkg::LEN_W'(1) << cur_exp;

	// full-width sample count for the drop check
	assign meas_cur = (rba_pkg::MEASX_W'(cur_comp) << cur_exp)
		+ rba_pkg::MEASX_W'(cur_fill);

	// ------------------------------------------------------------------
	// item decode
	// ------------------------------------------------------------------
	logic var_ok;
	logic full;
	logic blk_bad;
	logic acc_ok;
	logic need_merge;
	logic acc_commit;
	logic clr_all;
	logic rd_valid;
	logic acc_old_valid;

	assign var_ok  = rba_pkg::VCFG_W'(var_q) < vars_eff_q;
	assign full    = meas_cur >= rba_pkg::MEAS_FULL;
	assign blk_bad = rba_pkg::CNT_W'(blk_q) >= nb_q;

	assign acc_ok     = (op_q == rba_pkg::OP_ACC) && var_ok && !full;
	assign need_merge = ctrl.exec && acc_ok && (cur_comp >= nb_q);
	assign acc_commit = ctrl.commit && acc_ok;
	assign clr_all    = cfg_hit || (ctrl.commit && op_q == rba_pkg::OP_CLEAR);

	// stored entries past the current fill read as zero; valid are everything below
	// the count of completed blocks, plus the open block once it has a sample
	assign rd_valid = (rba_pkg::CNT_W'(blk_q) < cur_comp)
		|| ((rba_pkg::CNT_W'(blk_q) == cur_comp) && (cur_fill != '0));
	assign acc_old_valid = (cur_fill != '0);

	// ------------------------------------------------------------------
	// merge sweep: pair k of the row folds into entry k
	// ------------------------------------------------------------------
	logic [rba_pkg::PAIR_W-1:0]        pair_q;
	logic [rba_pkg::PAIR_W-1:0]        pair_nx;
	logic [rba_pkg::CNT_W-1:0]         half;
	logic                              merge_last;
	logic signed [rba_pkg::SUM_W-1:0]  mrg_a_q;
	logic [rba_pkg::EXP_W-1:0]         exp_inc;

	assign half       = nb_q >> 1;
	assign merge_last = rba_pkg::CNT_W'(pair_q) == (half - rba_pkg::CNT_W'(1));
	assign pair_nx    = pair_q + rba_pkg::PAIR_W'(1);
	assign exp_inc    = (cur_exp == rba_pkg::EXP_MAX) ? cur_exp
		: cur_exp + rba_pkg::EXP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (need_merge) begin
			pair_q <= '0;
		end else if (ctrl.mrg_w) begin
			pair_q <= pair_nx;
		end
	end

	assign stat.accept     = in_fire;
	assign stat.need_merge = need_merge;
	assign stat.out_free   = out_free;
	assign stat.merge_last = merge_last;

	// ------------------------------------------------------------------
	// block sum ram and the shared adder
	// ------------------------------------------------------------------
	logic                              rd_en;
	logic [rba_pkg::VAR_W-1:0]         rd_var;
	logic [rba_pkg::BLK_W-1:0]         rd_blk;
	logic signed [rba_pkg::SUM_W-1:0]  rd_data;
	logic                              wr_en;
	logic [rba_pkg::BLK_W-1:0]         wr_blk;
	logic signed [rba_pkg::SUM_W-1:0]  add_a;
	logic signed [rba_pkg::SUM_W-1:0]  add_b;
	logic signed [rba_pkg::SUM_W-1:0]  add_sum;
	logic signed [rba_pkg::SUM_W-1:0]  val_ext;

	assign val_ext = {{(rba_pkg::SUM_W-rba_pkg::VAL_W){val_q[rba_pkg::VAL_W-1]}}, val_q};

	// read address: the item's block on the accepted beat, merge operands
	// during the sweep, the new open block after a sweep
	always_comb begin
		rd_en  = 1'b0;
		rd_var = var_q;
		rd_blk = '0;
		priority if (in_fire) begin
			rd_en  = 1'b1;
			rd_var = var_index;
			rd_blk = (op == rba_pkg::OP_READ) ? block_index
				: comp_q[var_index][rba_pkg::BLK_W-1:0];
		end else if (ctrl.mrg_a) begin
			rd_en  = 1'b1;
			rd_blk = {pair_q, 1'b0};
		end else if (ctrl.mrg_b) begin
			rd_en  = 1'b1;
			rd_blk = {pair_q, 1'b1};
		end else if (ctrl.mrg_w) begin
			rd_en  = 1'b1;
			rd_blk = {pair_nx, 1'b0};
		end else if (ctrl.acc_rd) begin
			rd_en  = 1'b1;
			rd_blk = cur_comp[rba_pkg::BLK_W-1:0];
		end else begin
			rd_en  = 1'b0;
		end
	end

	// first merge operand parks here while the second is read
	always_ff @(posedge clk) begin
		if (ctrl.mrg_b) begin
			mrg_a_q <= rd_data;
		end
	end

	assign add_a = ctrl.mrg_w ? mrg_a_q : (acc_old_valid ? rd_data : '0);
	assign add_b = ctrl.mrg_w ? rd_data : val_ext;

	rba_sat_add u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	assign wr_en  = acc_commit || ctrl.mrg_w;
	assign wr_blk = ctrl.mrg_w ? rba_pkg::BLK_W'(pair_q) : cur_comp[rba_pkg::BLK_W-1:0];

	rba_sum_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({var_q, wr_blk}),
		.wr_data (add_sum),
		.rd_en   (rd_en),
		.rd_addr ({rd_var, rd_blk}),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// accumulate update
	// ------------------------------------------------------------------
	logic [rba_pkg::LEN_W-1:0]  fill_inc;
	logic                       close;
	logic [rba_pkg::CNT_W-1:0]  comp_nx;
	logic [rba_pkg::FILL_W-1:0] fill_nx;
	logic [rba_pkg::SQ_W:0]     sq_x;
	logic [rba_pkg::SQ_W-1:0]   sq_nx;

	assign fill_inc = rba_pkg::LEN_W'(cur_fill) + rba_pkg::LEN_W'(1);
	assign close    = fill_inc >= cur_len;
	assign comp_nx  = close ? cur_comp + rba_pkg::CNT_W'(1) : cur_comp;
	assign fill_nx  = close ? '0 : fill_inc[rba_pkg::FILL_W-1:0];
	assign sq_x     = {1'b0, cur_sq} + (rba_pkg::SQ_W+1)'(prod_q);
	assign sq_nx    = sq_x[rba_pkg::SQ_W] ? rba_pkg::SQ_MAX : sq_x[rba_pkg::SQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rba_pkg::NUM_VARS; i++) begin
				comp_q[i] <= '0;
				exp_q[i]  <= '0;
				fill_q[i] <= '0;
				sq_q[i]   <= '0;
			end
		end else if (clr_all) begin
			for (int i = 0; i < rba_pkg::NUM_VARS; i++) begin
				comp_q[i] <= '0;
				exp_q[i]  <= '0;
				fill_q[i] <= '0;
				sq_q[i]   <= '0;
			end
		end else begin
			if (acc_commit) begin
				comp_q[var_q] <= comp_nx;
				fill_q[var_q] <= fill_nx;
				sq_q[var_q]   <= sq_nx;
			end
			// end of sweep: half the blocks, each twice as long
			if (ctrl.mrg_w && merge_last) begin
				comp_q[var_q] <= half;
				exp_q[var_q]  <= exp_inc;
			end
		end
	end

	// ------------------------------------------------------------------
	// result beat
	// ------------------------------------------------------------------
	rba_pkg::status_t                  res_status;
	logic                              rep;
	logic [rba_pkg::CNT_W-1:0]         res_comp;
	logic [rba_pkg::LEN_W-1:0]         res_len;
	logic [rba_pkg::FILL_W-1:0]        res_fill;
	logic [rba_pkg::MEAS_W-1:0]        res_meas;
	logic signed [rba_pkg::SUM_W-1:0]  res_sum;
	logic [rba_pkg::SQ_W-1:0]          res_sq;

	always_comb begin
		res_status = rba_pkg::STS_OK;
		rep        = 1'b0;
		res_comp   = '0;
		res_len    = '0;
		res_fill   = '0;
		res_meas   = '0;
		res_sum    = '0;
		res_sq     = '0;
		unique case (op_q)
			rba_pkg::OP_CLEAR: begin
				res_len = rba_pkg::LEN_W'(1);
			end
			rba_pkg::OP_NONE: begin
				res_status = rba_pkg::STS_OK;
			end
			rba_pkg::OP_READ: begin
				if (!var_ok) begin
					res_status = rba_pkg::STS_BAD_VAR;
				end else begin
					rep = 1'b1;
					if (blk_bad) begin
						res_status = rba_pkg::STS_BAD_BLK;
					end else begin
						res_sum = rd_valid ? rd_data : '0;
					end
				end
			end
			rba_pkg::OP_ACC: begin
				if (!var_ok) begin
					res_status = rba_pkg::STS_BAD_VAR;
				end else begin
					rep = 1'b1;
					if (full) begin
						res_status = rba_pkg::STS_FULL;
					end else begin
						res_sum = add_sum;
					end
				end
			end
		endcase
		// variable state after the step
		if (rep) begin
			res_comp = acc_ok ? comp_nx : cur_comp;
			res_fill = acc_ok ? fill_nx : cur_fill;
			res_sq   = acc_ok ? sq_nx : cur_sq;
			res_len  = cur_len;
			res_meas = (rba_pkg::MEAS_W'(res_comp) << cur_exp) + rba_pkg::MEAS_W'(res_fill);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	rba_pkg::status_t                  status_q;
	logic [rba_pkg::CNT_W-1:0]         count_q;
	logic [rba_pkg::LEN_W-1:0]         length_q;
	logic [rba_pkg::FILL_W-1:0]        fill_out_q;
	logic [rba_pkg::MEAS_W-1:0]        meas_q;
	logic signed [rba_pkg::SUM_W-1:0]  sum_q;
	logic [rba_pkg::SQ_W-1:0]          sqsum_q;

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			status_q   <= res_status;
			count_q    <= res_comp;
			length_q   <= res_len;
			fill_out_q <= res_fill;
			meas_q     <= res_meas;
			sum_q      <= res_sum;
			sqsum_q    <= res_sq;
		end
	end

	assign status       = status_q;
	assign block_count  = count_q;
	assign block_length = length_q;
	assign partial_fill = fill_out_q;
	assign measurements = meas_q;
	assign block_sum    = sum_q;
	assign square_sum   = sqsum_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------

	// a variable never holds more completed blocks than the table
	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |-> cur_comp <= nb_q)
		else $error("completed blocks exceed table size");

	// the open block is always shorter than the block length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |-> rba_pkg::LEN_W'(cur_fill) < cur_len)
		else $error("partial fill reached block length");

	// merge writes stay in the lower half of the row
	a_merge_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mrg_w |-> rba_pkg::CNT_W'(pair_q) < half)
		else $error("merge write beyond lower half");

	// after a sweep the table has room for the open block again
	a_merge_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mrg_w && merge_last |=> cur_comp == half && cur_comp < nb_q)
		else $error("merge sweep left table full");

	// a committed item always shows up as a result beat
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> out_valid)
		else $error("committed item without result beat");

endmodule

`default_nettype wire

// ===== verif/rebinning_block_accumulator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rebinning_block_accumulator_top_tb
// self-checking bench for the per-variable block accumulator: a short table
// of directed beats, then random beats under several configurations, every
// result beat checked field by field against typed-in values or a behavioral
// model of the binning tables kept inside the bench
// ----------------------------------------------------------------------------

module rebinning_block_accumulator_top_tb;

	import rba_pkg::*;

	// register index with no register behind it, a write must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

	localparam int unsigned LONG_HOLD     = 200;   // receiver hold-off for back-pressure
	localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any accepted beat
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_REPORTS   = 40;

	// random phases: raw register values and beat counts
	localparam int N_PHASES = 6;
	localparam int PHASE_VARS   [N_PHASES] = '{0, 16, 5, 31, 2, 16};
	localparam int PHASE_BLOCKS [N_PHASES] = '{127, 2, 7, 1, 65, 64};
	localparam int PHASE_BEATS  [N_PHASES] = '{140, 60, 60, 50, 50, 40};

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [CNT_W-1:0]  count;
		logic [LEN_W-1:0]  length;
		logic [FILL_W-1:0] fill;
		logic [MEAS_W-1:0] meas;
		logic [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]   sq;
	} bin_result_t;

	// one row of stimulus: a register write or an item beat
	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		logic [OP_W-1:0]       op;
		logic [VAR_W-1:0]      vi;
		logic [VAL_W-1:0]      val;
		logic [BLK_W-1:0]      blk;
		logic                  lit;   // want below is typed in, not predicted
		bin_result_t           want;
	} probe_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          op;
	logic [VAR_W-1:0]         var_index;
	logic signed [VAL_W-1:0]  value;
	logic [BLK_W-1:0]         block_index;
	logic                     out_valid;
	logic                     out_stall;
	logic [STS_W-1:0]         status;
	logic [CNT_W-1:0]         block_count;
	logic [LEN_W-1:0]         block_length;
	logic [FILL_W-1:0]        partial_fill;
	logic [MEAS_W-1:0]        measurements;
	logic signed [SUM_W-1:0]  block_sum;
	logic [SQ_W-1:0]          square_sum;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	// model of the binning tables and the two registers
	logic signed [SUM_W-1:0] sum_mem     [DEPTH];
	logic [SQ_W-1:0]         sq_acc      [NUM_VARS];
	logic [CNT_W-1:0]        done_blocks [NUM_VARS];
	logic [EXP_W-1:0]        len_exp     [NUM_VARS];
	logic [FILL_W-1:0]       fill_cnt    [NUM_VARS];
	int unsigned             reg_vars;
	int unsigned             reg_blocks;

	bin_result_t awaited_reports [$];
	probe_row_t  probes [$];
	int unsigned mismatches;
	int unsigned hold_requests;
	int unsigned holds_served;
	bit          quiet;

	rebinning_block_accumulator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.var_index    (var_index),
		.value        (value),
		.block_index  (block_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.block_count  (block_count),
		.block_length (block_length),
		.partial_fill (partial_fill),
		.measurements (measurements),
		.block_sum    (block_sum),
		.square_sum   (square_sum),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the accumulator
	// ------------------------------------------------------------------

	function automatic void wipe_bins();
		for (int k = 0; k < DEPTH; k++) sum_mem[k] = '0;
		for (int k = 0; k < NUM_VARS; k++) begin
			sq_acc[k] = '0;
			done_blocks[k] = '0;
			len_exp[k] = '0;
			fill_cnt[k] = '0;
		end
	endfunction

	// register values as the block uses them
	function automatic int unsigned vars_limit();
		int unsigned v;
		v = reg_vars;
		if (v < 1) v = 1;
		if (v > NUM_VARS) v = NUM_VARS;
		return v;
	endfunction

	function automatic int unsigned blocks_limit();
		int unsigned b;
		b = reg_blocks & ~32'd1;
		if (b > MAX_BLOCKS) b = MAX_BLOCKS;
		if (b < 2) b = 2;
		return b;
	endfunction

	function automatic longint unsigned count_so_far(int unsigned v);
		return (64'(done_blocks[v]) << len_exp[v]) + 64'(fill_cnt[v]);
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] a,
			logic signed [SUM_W-1:0] b);
		logic signed [SUM_W:0] s;
		s = a + b;
		if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
		return s[SUM_W-1:0];
	endfunction

	function automatic bin_result_t report_of(int unsigned v, logic [STS_W-1:0] sts,
			logic [SUM_W-1:0] sum);
		bin_result_t res;
		res.status = sts;
		res.count  = done_blocks[v];
		res.length = LEN_W'(64'd1 << len_exp[v]);
		res.fill   = fill_cnt[v];
		res.meas   = MEAS_W'(count_so_far(v));
		res.sum    = sum;
		res.sq     = sq_acc[v];
		return res;
	endfunction

	// applies one item to the model and returns the result beat it causes
	function automatic bin_result_t predict_report(probe_row_t r);
		bin_result_t             res;
		int unsigned             v, nb, base, cur;
		logic signed [SUM_W-1:0] sample;
		longint                  sq_full;
		logic [SQ_W-1:0]         sq;
		res = '0;
		v = r.vi;
		nb = blocks_limit();
		base = v * MAX_BLOCKS;
		case (op_t'(r.op))
			OP_CLEAR: begin
				wipe_bins();
				res.length = 1;
				return res;
			end
			OP_NONE: return res;
			default: ;
		endcase
		if (v >= vars_limit()) begin
			res.status = STS_BAD_VAR;
			return res;
		end
		if (op_t'(r.op) == OP_READ) begin
			if (r.blk >= nb) return report_of(v, STS_BAD_BLK, '0);
			return report_of(v, STS_OK, sum_mem[base + r.blk]);
		end
		// accumulate; a full measurement count drops the sample
		if (count_so_far(v) >= 64'hFFFF_FFFF) return report_of(v, STS_FULL, '0);
		if (done_blocks[v] >= nb) begin
			// table full: fold pairs into the lower half, double the length
			for (int k = 0; k < nb / 2; k++)
				sum_mem[base + k] = sat_sum(sum_mem[base + 2 * k], sum_mem[base + 2 * k + 1]);
			for (int k = nb / 2; k < nb; k++) sum_mem[base + k] = '0;
			done_blocks[v] = CNT_W'(nb / 2);
			if (len_exp[v] < 31) len_exp[v] = len_exp[v] + 1'b1;
		end
		cur = done_blocks[v];
		sample = SUM_W'($signed(r.val));
		sum_mem[base + cur] = sat_sum(sum_mem[base + cur], sample);
		sq_full = $signed(r.val) * $signed(r.val);
		sq = SQ_W'(sq_full);
		if (sq_acc[v] > SQ_MAX - sq) sq_acc[v] = SQ_MAX;
		else sq_acc[v] = sq_acc[v] + sq;
		fill_cnt[v] = fill_cnt[v] + 1'b1;
		if (64'(fill_cnt[v]) >= (64'd1 << len_exp[v])) begin
			done_blocks[v] = CNT_W'(cur + 1);
			fill_cnt[v] = '0;
		end
		return report_of(v, STS_OK, sum_mem[base + cur]);
	endfunction

	// ------------------------------------------------------------------
	// stimulus rows
	// ------------------------------------------------------------------

	function automatic probe_row_t beat_row(op_t o, int vi, int val, int blk);
		probe_row_t r;
		r = '0;
		r.op  = o;
		r.vi  = VAR_W'(vi);
		r.val = VAL_W'(val);
		r.blk = BLK_W'(blk);
		return r;
	endfunction

	// beat whose result is all zero but for status and block length
	function automatic probe_row_t known_row(op_t o, int vi, int val, int blk,
			logic [STS_W-1:0] sts, logic [LEN_W-1:0] len);
		probe_row_t r;
		r = beat_row(o, vi, val, blk);
		r.lit = 1'b1;
		r.want.status = sts;
		r.want.length = len;
		return r;
	endfunction

	function automatic probe_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
		probe_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	// mostly accumulates, hammering one hot variable so tables fill and fold
	function automatic probe_row_t random_row(int unsigned hot);
		op_t         o;
		int unsigned pick, vi, blk;
		int          val;
		pick = $urandom_range(0, 99);
		if (pick < 74) o = OP_ACC;
		else if (pick < 96) o = OP_READ;
		else if (pick < 99) o = OP_NONE;
		else o = OP_CLEAR;
		pick = $urandom_range(0, 9);
		if (pick == 0) vi = $urandom_range(0, NUM_VARS - 1);
		else if (pick < 5) vi = hot;
		else vi = $urandom_range(0, vars_limit() - 1);
		case ($urandom_range(0, 5))
			0: val = 8388607;
			1: val = -8388608;
			2: val = int'($urandom_range(0, 511)) - 256;
			default: val = int'($urandom());
		endcase
		if ($urandom_range(0, 6) == 0) blk = $urandom_range(0, MAX_BLOCKS - 1);
		else blk = $urandom_range(0, blocks_limit() - 1);
		return beat_row(o, vi, val, blk);
	endfunction

	// cycles one side waits before its next beat
	function automatic int unsigned pace();
		if (quiet || $urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	// ------------------------------------------------------------------
	// item side
	// ------------------------------------------------------------------

	task automatic send_beat(input probe_row_t r, input int unsigned gap);
		bin_result_t got;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= r.op;
		var_index   <= r.vi;
		value       <= r.val;
		block_index <= r.blk;
		do @(posedge clk); while (in_stall);
		// model runs even where the result is typed in, to keep its state
		got = predict_report(r);
		awaited_reports.push_back(r.lit ? r.want : got);
	endtask

	// wait for every owed result, then let the bench settle
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		// any real register write also clears every variable
		case (idx)
			CFG_VARS: begin
				reg_vars = val & 'h1F;
				wipe_bins();
			end
			CFG_BLOCKS: begin
				reg_blocks = val & 'h7F;
				wipe_bins();
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$error("%s: expected %0h, got %0h", name, want, seen);
		end
	endtask

	task automatic check_report();
		bin_result_t want;
		if (awaited_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) $error("result beat with nothing owed");
			return;
		end
		want = awaited_reports.pop_front();
		check_field("status", want.status, status);
		check_field("block_count", want.count, block_count);
		check_field("block_length", want.length, block_length);
		check_field("partial_fill", want.fill, partial_fill);
		check_field("measurements", want.meas, measurements);
		check_field("block_sum", want.sum, {8'd0, block_sum});
		check_field("square_sum", want.sq, square_sum);
	endtask

	// receiver: random hold-off after each beat, plus one long hold on request
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_report();
				stall_left = pace();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_requests != holds_served) begin
				holds_served++;
				stall_left = LONG_HOLD;
			end
			out_stall <= (stall_left > 0);
		end
	end

	// watchdog: ends the run when no beat moves for too long
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		int unsigned burst, hot;
		// every input known from time zero
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_ACC;
		var_index     = '0;
		value         = '0;
		block_index   = '0;
		out_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_VARS;
		cfg_data      = '0;
		mismatches    = 0;
		hold_requests = 0;
		holds_served  = 0;
		quiet         = 1'b0;
		burst         = 0;
		reg_vars      = NUM_VARS;
		reg_blocks    = MAX_BLOCKS;
		wipe_bins();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		probes = '{
			// empty tables straight after reset
			known_row(OP_READ, 0, 0, 0, STS_OK, 1),
			known_row(OP_READ, 15, -1, 63, STS_OK, 1),
			// extreme samples, length one closes a block per sample
			beat_row(OP_ACC, 0, 8388607, 0),
			beat_row(OP_ACC, 0, -8388608, 63),
			beat_row(OP_ACC, 15, -1, 0),
			beat_row(OP_ACC, 15, 0, 21),
			beat_row(OP_READ, 0, 0, 0),
			beat_row(OP_READ, 0, 0, 1),
			// unused op does nothing
			known_row(OP_NONE, 10, 'h5A5A5A, 42, STS_OK, 0),
			// clear all, then read back an emptied block
			known_row(OP_CLEAR, 3, 'h3C3C3C, 21, STS_OK, 1),
			known_row(OP_READ, 0, 0, 1, STS_OK, 1),
			// three variables, odd block setting rounds down to four
			reg_row(CFG_VARS, 3),
			reg_row(CFG_BLOCKS, 5),
			known_row(OP_ACC, 3, 1, 0, STS_BAD_VAR, 0),
			known_row(OP_READ, 12, 0, 0, STS_BAD_VAR, 0),
			known_row(OP_READ, 0, 0, 4, STS_BAD_BLK, 1),
			known_row(OP_READ, 0, 0, 63, STS_BAD_BLK, 1),
			// fill four blocks, the fifth sample folds the pairs
			beat_row(OP_ACC, 2, 8388607, 0),
			beat_row(OP_ACC, 2, 8388607, 0),
			beat_row(OP_ACC, 2, -5, 0),
			beat_row(OP_ACC, 2, 'h123456, 0),
			beat_row(OP_ACC, 2, -8388608, 0),
			beat_row(OP_ACC, 2, 7, 0),
			beat_row(OP_READ, 2, 0, 0),
			beat_row(OP_READ, 2, 0, 3),
			beat_row(OP_READ, 1, 0, 1)
		};
		foreach (probes[n]) begin
			if (probes[n].is_cfg) begin
				settle_idle();
				write_reg(probes[n].cfg_idx, probes[n].cfg_val);
			end else begin
				send_beat(probes[n], pace());
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < N_PHASES; p++) begin
			settle_idle();
			write_reg(CFG_VARS, PHASE_VARS[p]);
			write_reg(CFG_BLOCKS, PHASE_BLOCKS[p]);
			quiet = (p == 3);
			hot = $urandom_range(0, vars_limit() - 1);
			for (int i = 0; i < PHASE_BEATS[p]; i++) begin
				if (p == 0 && i == 20) begin
					// receiver holds off while beats keep coming back to back
					hold_requests++;
					burst = 16;
				end
				if (p == 0 && i == 70) begin
					// write to an unused index must leave the tables alone
					settle_idle();
					write_reg(CFG_SPARE, $urandom_range(0, 127));
				end
				send_beat(random_row(hot), (burst > 0) ? 0 : pace());
				if (burst > 0) burst--;
			end
		end

		settle_idle();
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// ===== rebinning_block_accumulator_top.f =====
rtl/rba_pkg.sv
rtl/rba_sum_ram.sv
rtl/rba_sat_add.sv
rtl/rba_seq.sv
rtl/rebinning_block_accumulator_top.sv
verif/rebinning_block_accumulator_top_tb.sv
